### rtl/core/nfcs_pkg.sv
// nfcs_pkg: shared types and constants for the NOR flash command sequencer.
// No dependencies; every other file of the block uses this package.
package nfcs_pkg;

    localparam int ADDR_W = 21;
    localparam int DATA_W = 16;
    localparam int STAT_W = 3;

    // defaults for the top-level parameters
    localparam int DEF_SECTOR_COUNT = 13;
    localparam int DEF_SECTOR_WORDS = 32768;
    localparam int DEF_ADDRESS_BITS = 21;

    // job queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    // request command codes
    localparam logic [1:0] CMD_PROGRAM  = 2'd0;
    localparam logic [1:0] CMD_ERASE    = 2'd1;
    localparam logic [1:0] CMD_BLANK    = 2'd2;
    localparam logic [1:0] CMD_RESPONSE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_BUS        = 3'd0;
    localparam logic [STAT_W-1:0] ST_WORD_DONE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_SUCCESS    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ERASED = 3'd3;
    localparam logic [STAT_W-1:0] ST_BLANK      = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_BLANK  = 3'd5;

    // job kinds handed from front to back
    localparam logic [1:0] JOB_READ   = 2'd0;
    localparam logic [1:0] JOB_STATUS = 2'd1;
    localparam logic [1:0] JOB_PROG   = 2'd2;
    localparam logic [1:0] JOB_ERASE  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] status;
    } job_t;

endpackage

### rtl/core/nfcs_req_if.sv
// nfcs_req_if: request channel into the sequencer, valid/ready handshake.
// Depends on nfcs_pkg for field widths.
interface nfcs_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [nfcs_pkg::ADDR_W-1:0]   word_address;
    logic [3:0]                    sector_number;
    logic [nfcs_pkg::DATA_W-1:0]   data_word;
    logic                          final_word;

    modport source (
        output valid, command, word_address, sector_number, data_word, final_word,
        input  ready
    );
    modport sink (
        input  valid, command, word_address, sector_number, data_word, final_word,
        output ready
    );
endinterface

### rtl/core/nfcs_rsp_if.sv
// nfcs_rsp_if: result channel out of the sequencer, valid/ready handshake.
// Depends on nfcs_pkg for field widths.
interface nfcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          bus_write;
    logic [nfcs_pkg::ADDR_W-1:0]   bus_address;
    logic [nfcs_pkg::DATA_W-1:0]   bus_data;
    logic [nfcs_pkg::STAT_W-1:0]   status;
    logic                          last;

    modport source (
        output valid, bus_write, bus_address, bus_data, status, last,
        input  ready
    );
    modport sink (
        input  valid, bus_write, bus_address, bus_data, status, last,
        output ready
    );
endinterface

### rtl/core/nor_flash_command_sequencer_unit.sv
// nor_flash_command_sequencer_unit: top level of the NOR flash sequencer.
// Throughput: one request per cycle in unless the queue is full, one result per
// cycle out unless rsp.ready stalls; a request yields up to seven results, so
// the output rate and the queue depth set pace.
// Reset: rst_n asynchronous active low, clears phase, queue and output valid.
module nor_flash_command_sequencer_unit #(
    parameter int SECTOR_COUNT = nfcs_pkg::DEF_SECTOR_COUNT,
    parameter int SECTOR_WORDS = nfcs_pkg::DEF_SECTOR_WORDS,
    parameter int ADDRESS_BITS = nfcs_pkg::DEF_ADDRESS_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    nfcs_req_if.sink   req,
    nfcs_rsp_if.source rsp
);
    import nfcs_pkg::*;

    // Front end: classifies each request against the current phase and
    // updates the phase state at once, so the next request can follow in
    // the next cycle. Requests that cause results push one job each.
    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic full;
    logic head_valid;

    nfcs_front #(
        .SECTOR_COUNT (SECTOR_COUNT),
        .SECTOR_WORDS (SECTOR_WORDS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    // Queue of pending jobs; front stalls only when it fills.
    nfcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: expands each job (unlock writes, program or erase command,
    // poll read, status) into results through a registered output stage.
    nfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .rsp        (rsp)
    );

`ifndef SYNTHESIS
    // status results always close a request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_BUS |-> rsp.last)
        else $error("status result not marked last");

    // a write cycle is never the last result of a request
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bus_write |-> rsp.status == ST_BUS && !rsp.last)
        else $error("write cycle marked last or with status");

    // a queued job is taken by the back end whenever the output stage is free
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !rsp.valid |=> rsp.valid)
        else $error("back end did not load a pending job");
`endif

endmodule

### rtl/core/nfcs_front.sv
// nfcs_front: accepts requests, runs the operation phase machine and
// pushes one job per result-producing request. Depends on nfcs_pkg, nfcs_req_if.
module nfcs_front #(
    parameter int SECTOR_COUNT = nfcs_pkg::DEF_SECTOR_COUNT,
    parameter int SECTOR_WORDS = nfcs_pkg::DEF_SECTOR_WORDS,
    parameter int ADDRESS_BITS = nfcs_pkg::DEF_ADDRESS_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    nfcs_req_if.sink       req,
    input  logic           full,
    output logic           push,
    output nfcs_pkg::job_t push_job
);
    import nfcs_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PCHECK = 3'd1;
    localparam logic [2:0] PH_PPOLL1 = 3'd2;
    localparam logic [2:0] PH_PPOLL2 = 3'd3;
    localparam logic [2:0] PH_EPOLL1 = 3'd4;
    localparam logic [2:0] PH_EPOLL2 = 3'd5;
    localparam logic [2:0] PH_BLANK  = 3'd6;

    localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;
    localparam logic [ADDR_W-1:0] AMASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                        : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] SECTOR_WORDS_A = ADDR_W'(SECTOR_WORDS);
    localparam logic [15:0]       WORDS_LAST     = 16'(SECTOR_WORDS - 1);
    localparam logic [6:0]        SECTOR_LIMIT   = 7'(SECTOR_COUNT);

    logic [2:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic [DATA_W-1:0] pending_reg, pending_next;
    logic              final_reg, final_next;
    logic [DATA_W-1:0] first_poll_reg, first_poll_next;
    logic [15:0]       remaining_reg, remaining_next;

    logic              accept;
    logic              sector_ok;
    logic [ADDR_W-1:0] sector_base;
    logic [ADDR_W-1:0] target_inc;

    assign req.ready   = !full;
    assign accept      = req.valid && !full;
    assign sector_ok   = ({3'b000, req.sector_number} < SECTOR_LIMIT);
    assign sector_base = (ADDR_W'(req.sector_number) * SECTOR_WORDS_A) & AMASK;
    assign target_inc  = (target_reg + {{(ADDR_W-1){1'b0}}, 1'b1}) & AMASK;

    always_comb
    begin
        phase_next      = phase_reg;
        target_next     = target_reg;
        pending_next    = pending_reg;
        final_next      = final_reg;
        first_poll_next = first_poll_reg;
        remaining_next  = remaining_reg;
        push            = 1'b0;
        push_job        = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.command == CMD_PROGRAM)
                    begin
                        target_next   = req.word_address & AMASK;
                        pending_next  = req.data_word;
                        final_next    = req.final_word;
                        push          = 1'b1;
                        push_job.kind = JOB_READ;
                        push_job.addr = req.word_address & AMASK;
                        phase_next    = PH_PCHECK;
                    end
                    else if ((req.command == CMD_ERASE || req.command == CMD_BLANK)
                             && sector_ok)
                    begin
                        target_next   = sector_base;
                        push          = 1'b1;
                        push_job.addr = sector_base;
                        if (req.command == CMD_ERASE)
                        begin
                            push_job.kind = JOB_ERASE;
                            phase_next    = PH_EPOLL1;
                        end
                        else
                        begin
                            push_job.kind  = JOB_READ;
                            remaining_next = WORDS_LAST;
                            phase_next     = PH_BLANK;
                        end
                    end
                end
                default:
                begin
                    if (req.command == CMD_RESPONSE)
                    begin
                        push = 1'b1;
                        case (phase_reg)
                            PH_PCHECK:
                            begin
                                if (req.data_word != ERASED_WORD)
                                begin
                                    push_job.kind   = JOB_STATUS;
                                    push_job.status = ST_NOT_ERASED;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    push_job.kind = JOB_PROG;
                                    push_job.addr = target_reg;
                                    push_job.data = pending_reg;
                                    phase_next    = PH_PPOLL1;
                                end
                            end
                            PH_PPOLL1, PH_EPOLL1:
                            begin
                                first_poll_next = req.data_word;
                                push_job.kind   = JOB_READ;
                                push_job.addr   = target_reg;
                                phase_next      = (phase_reg == PH_PPOLL1) ? PH_PPOLL2
                                                                           : PH_EPOLL2;
                            end
                            PH_PPOLL2, PH_EPOLL2:
                            begin
                                if (req.data_word == first_poll_reg)
                                begin
                                    push_job.kind   = JOB_STATUS;
                                    push_job.status = (phase_reg == PH_PPOLL2 && !final_reg)
                                                      ? ST_WORD_DONE : ST_SUCCESS;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    push_job.kind = JOB_READ;
                                    push_job.addr = target_reg;
                                    phase_next    = (phase_reg == PH_PPOLL2) ? PH_PPOLL1
                                                                             : PH_EPOLL1;
                                end
                            end
                            PH_BLANK:
                            begin
                                if (req.data_word != ERASED_WORD)
                                begin
                                    push_job.kind   = JOB_STATUS;
                                    push_job.status = ST_NOT_BLANK;
                                    phase_next      = PH_IDLE;
                                end
                                else if (remaining_reg == 16'd0)
                                begin
                                    push_job.kind   = JOB_STATUS;
                                    push_job.status = ST_BLANK;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    remaining_next = remaining_reg - 16'd1;
                                    target_next    = target_inc;
                                    push_job.kind  = JOB_READ;
                                    push_job.addr  = target_inc;
                                end
                            end
                            default:
                            begin
                                push       = 1'b0;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            target_reg     <= '0;
            pending_reg    <= '0;
            final_reg      <= 1'b0;
            first_poll_reg <= '0;
            remaining_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            pending_reg    <= pending_next;
            final_reg      <= final_next;
            first_poll_reg <= first_poll_next;
            remaining_reg  <= remaining_next;
        end
    end

endmodule

### rtl/core/nfcs_queue.sv
// nfcs_queue: short job queue between front and back ends.
// Depends on nfcs_pkg for job_t and the depth.
module nfcs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nfcs_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output nfcs_pkg::job_t head_job
);
    import nfcs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_C = (PTR_W+1)'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/nfcs_back.sv
// nfcs_back: expands queued jobs into registered bus-cycle and status results,
// one per cycle unless rsp.ready stalls. Depends on nfcs_pkg, nfcs_rsp_if.
module nfcs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  nfcs_pkg::job_t head_job,
    output logic           pop,
    nfcs_rsp_if.source     rsp
);
    import nfcs_pkg::*;

    localparam logic [ADDR_W-1:0] UNLOCK_A = 21'h05555;
    localparam logic [ADDR_W-1:0] UNLOCK_B = 21'h02AAA;
    localparam logic [DATA_W-1:0] D_AA = 16'h00AA;
    localparam logic [DATA_W-1:0] D_55 = 16'h0055;
    localparam logic [DATA_W-1:0] D_A0 = 16'h00A0;
    localparam logic [DATA_W-1:0] D_80 = 16'h0080;
    localparam logic [DATA_W-1:0] D_30 = 16'h0030;

    logic [2:0]        step_reg, step_next;
    logic              valid_reg, valid_next;
    logic              write_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic [STAT_W-1:0] status_reg;
    logic              last_reg;

    logic              load;
    logic              it_write;
    logic [ADDR_W-1:0] it_addr;
    logic [DATA_W-1:0] it_data;
    logic [STAT_W-1:0] it_status;
    logic              it_last;

    // item selected by job kind and step within the job
    always_comb
    begin
        it_write  = 1'b0;
        it_addr   = head_job.addr;
        it_data   = '0;
        it_status = ST_BUS;
        it_last   = 1'b1;
        case (head_job.kind)
            JOB_STATUS:
            begin
                it_addr   = '0;
                it_status = head_job.status;
            end
            JOB_PROG:
            begin
                it_last = 1'b0;
                case (step_reg)
                    3'd0:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_A; it_data = D_AA;
                    end
                    3'd1:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_B; it_data = D_55;
                    end
                    3'd2:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_A; it_data = D_A0;
                    end
                    3'd3:
                    begin
                        it_write = 1'b1; it_data = head_job.data;
                    end
                    default:
                    begin
                        it_last = 1'b1;
                    end
                endcase
            end
            JOB_ERASE:
            begin
                it_last = 1'b0;
                case (step_reg)
                    3'd0:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_A; it_data = D_AA;
                    end
                    3'd1:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_B; it_data = D_55;
                    end
                    3'd2:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_A; it_data = D_80;
                    end
                    3'd3:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_A; it_data = D_AA;
                    end
                    3'd4:
                    begin
                        it_write = 1'b1; it_addr = UNLOCK_B; it_data = D_55;
                    end
                    3'd5:
                    begin
                        it_write = 1'b1; it_data = D_30;
                    end
                    default:
                    begin
                        it_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                it_last = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!valid_reg || rsp.ready);
    assign pop  = load && it_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = it_last ? 3'd0 : step_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            write_reg  <= it_write;
            addr_reg   <= it_addr;
            data_reg   <= it_data;
            status_reg <= it_status;
            last_reg   <= it_last;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.bus_write   = write_reg;
    assign rsp.bus_address = addr_reg;
    assign rsp.bus_data    = data_reg;
    assign rsp.status      = status_reg;
    assign rsp.last        = last_reg;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for nor_flash_command_sequencer_unit.
// Needs nfcs_pkg, nfcs_req_if, nfcs_rsp_if and the sequencer RTL under test.
// Requests go through a driver queue; results are checked against a local predictor.
module tb;
    import nfcs_pkg::*;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;

    // geometry, same as the defaults the block is built with
    localparam int SECTORS     = DEF_SECTOR_COUNT;
    localparam int SECTOR_SIZE = DEF_SECTOR_WORDS;
    localparam int TARGET_REQS = 210;

    // flash command set constants
    localparam data_t ERASED      = 16'hFFFF;
    localparam addr_t UNLOCK_A    = 21'h05555;
    localparam addr_t UNLOCK_B    = 21'h02AAA;
    localparam data_t UNLOCK_1    = 16'h00AA;
    localparam data_t UNLOCK_2    = 16'h0055;
    localparam data_t PROG_SETUP  = 16'h00A0;
    localparam data_t ERASE_SETUP = 16'h0080;
    localparam data_t SECTOR_ERA  = 16'h0030;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PROG_CHECK,
        SEQ_PROG_POLL_A,
        SEQ_PROG_POLL_B,
        SEQ_ERASE_POLL_A,
        SEQ_ERASE_POLL_B,
        SEQ_BLANK_SCAN
    } seq_state_t;

    // one request as the driver will present it; pace selects the idling mix
    typedef struct packed {
        logic [1:0] command;
        addr_t      word_address;
        logic [3:0] sector_number;
        data_t      data_word;
        logic       final_word;
        logic [1:0] pace;
    } flash_req_t;

    typedef struct packed {
        logic              bus_write;
        addr_t             bus_address;
        data_t             bus_data;
        logic [STAT_W-1:0] status;
        logic              last;
    } flash_result_t;

    logic clk;
    logic rst_n;

    nfcs_req_if req_ch ();
    nfcs_rsp_if rsp_ch ();

    nor_flash_command_sequencer_unit #(
        .SECTOR_COUNT (SECTORS),
        .SECTOR_WORDS (SECTOR_SIZE),
        .ADDRESS_BITS (DEF_ADDRESS_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    flash_req_t    pending_requests [$];
    flash_result_t expected_results [$];

    // generator bookkeeping
    logic [1:0] gen_pace = 2'd0;
    bit         busy_noise_on = 1'b0;
    int         counted_reqs = 0;

    // driver / monitor bookkeeping
    bit         req_fired = 1'b0;
    logic [1:0] drive_pace = 2'd0;
    int         mismatch_count = 0;

    // predictor state
    seq_state_t    seq_state   = SEQ_IDLE;
    addr_t         target_addr = '0;
    data_t         prog_data   = '0;
    logic          prog_final  = 1'b0;
    data_t         first_poll  = '0;
    logic [15:0]   words_left  = '0;
    flash_result_t pred_batch [7];
    int            pred_count;

    // ------------------------------------------------------------------
    // Clock: 4 ns period.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: follows the sequencer phase by phase and queues the
    // results each accepted request should produce, last flag included.
    // ------------------------------------------------------------------
    function automatic void emit(input logic wr, input addr_t addr, input data_t data,
                                 input logic [STAT_W-1:0] st);
        pred_batch[pred_count] = '{bus_write: wr, bus_address: addr, bus_data: data,
                                   status: st, last: 1'b0};
        pred_count++;
    endfunction

    task automatic predict_request(input logic [1:0] cmd, input addr_t waddr,
                                   input logic [3:0] sector, input data_t rdata,
                                   input logic fin);
        pred_count = 0;
        if (seq_state == SEQ_IDLE)
        begin
            if (cmd == CMD_PROGRAM)
            begin
                // read the target first to see whether it is still erased
                target_addr = waddr;
                prog_data   = rdata;
                prog_final  = fin;
                emit(1'b0, target_addr, '0, ST_BUS);
                seq_state = SEQ_PROG_CHECK;
            end
            else if ((cmd == CMD_ERASE || cmd == CMD_BLANK) && int'(sector) < SECTORS)
            begin
                target_addr = addr_t'(int'(sector) * SECTOR_SIZE);
                if (cmd == CMD_ERASE)
                begin
                    emit(1'b1, UNLOCK_A, UNLOCK_1, ST_BUS);
                    emit(1'b1, UNLOCK_B, UNLOCK_2, ST_BUS);
                    emit(1'b1, UNLOCK_A, ERASE_SETUP, ST_BUS);
                    emit(1'b1, UNLOCK_A, UNLOCK_1, ST_BUS);
                    emit(1'b1, UNLOCK_B, UNLOCK_2, ST_BUS);
                    emit(1'b1, target_addr, SECTOR_ERA, ST_BUS);
                    emit(1'b0, target_addr, '0, ST_BUS);
                    seq_state = SEQ_ERASE_POLL_A;
                end
                else
                begin
                    words_left = 16'(SECTOR_SIZE - 1);
                    emit(1'b0, target_addr, '0, ST_BUS);
                    seq_state = SEQ_BLANK_SCAN;
                end
            end
            // responses while idle and out-of-range sectors fall through silently
        end
        else if (cmd == CMD_RESPONSE)
        begin
            case (seq_state)
                SEQ_PROG_CHECK:
                begin
                    if (rdata != ERASED)
                    begin
                        emit(1'b0, '0, '0, ST_NOT_ERASED);
                        seq_state = SEQ_IDLE;
                    end
                    else
                    begin
                        emit(1'b1, UNLOCK_A, UNLOCK_1, ST_BUS);
                        emit(1'b1, UNLOCK_B, UNLOCK_2, ST_BUS);
                        emit(1'b1, UNLOCK_A, PROG_SETUP, ST_BUS);
                        emit(1'b1, target_addr, prog_data, ST_BUS);
                        emit(1'b0, target_addr, '0, ST_BUS);
                        seq_state = SEQ_PROG_POLL_A;
                    end
                end
                SEQ_PROG_POLL_A, SEQ_ERASE_POLL_A:
                begin
                    first_poll = rdata;
                    emit(1'b0, target_addr, '0, ST_BUS);
                    seq_state = (seq_state == SEQ_PROG_POLL_A) ? SEQ_PROG_POLL_B
                                                               : SEQ_ERASE_POLL_B;
                end
                SEQ_PROG_POLL_B, SEQ_ERASE_POLL_B:
                begin
                    // toggle bit settled once both reads of a pair agree
                    if (rdata == first_poll)
                    begin
                        if (seq_state == SEQ_PROG_POLL_B && !prog_final)
                            emit(1'b0, '0, '0, ST_WORD_DONE);
                        else
                            emit(1'b0, '0, '0, ST_SUCCESS);
                        seq_state = SEQ_IDLE;
                    end
                    else
                    begin
                        emit(1'b0, target_addr, '0, ST_BUS);
                        seq_state = (seq_state == SEQ_PROG_POLL_B) ? SEQ_PROG_POLL_A
                                                                   : SEQ_ERASE_POLL_A;
                    end
                end
                SEQ_BLANK_SCAN:
                begin
                    if (rdata != ERASED)
                    begin
                        emit(1'b0, '0, '0, ST_NOT_BLANK);
                        seq_state = SEQ_IDLE;
                    end
                    else if (words_left == 16'd0)
                    begin
                        emit(1'b0, '0, '0, ST_BLANK);
                        seq_state = SEQ_IDLE;
                    end
                    else
                    begin
                        words_left  = words_left - 16'd1;
                        target_addr = target_addr + addr_t'(1);
                        emit(1'b0, target_addr, '0, ST_BUS);
                    end
                end
                default:
                    seq_state = SEQ_IDLE;
            endcase
        end
        // new requests while busy are dropped by the block

        if (pred_count > 0)
            pred_batch[pred_count-1].last = 1'b1;
        for (int i = 0; i < pred_count; i++)
            expected_results.push_back(pred_batch[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders. Sequences are built to be well formed; busy noise
    // (a fresh request mid-sequence) is sprinkled in when enabled.
    // ------------------------------------------------------------------
    task automatic push_request(input logic [1:0] cmd, input addr_t addr,
                                input logic [3:0] sector, input data_t data,
                                input logic fin, input bit counted);
        pending_requests.push_back('{command: cmd, word_address: addr,
                                     sector_number: sector, data_word: data,
                                     final_word: fin, pace: gen_pace});
        if (counted)
            counted_reqs++;
    endtask

    function automatic data_t not_erased_word();
        data_t w;
        do
            w = data_t'($urandom);
        while (w == ERASED);
        return w;
    endfunction

    task automatic queue_response(input data_t data);
        if (busy_noise_on && $urandom_range(9) == 0)
            push_request(2'($urandom_range(2)), addr_t'($urandom), 4'($urandom),
                         data_t'($urandom), 1'($urandom), 1'b0);
        push_request(CMD_RESPONSE, addr_t'($urandom), 4'($urandom), data, 1'($urandom), 1'b1);
    endtask

    // toggle polling: every pair but the last differs
    task automatic queue_polls(input int pairs);
        data_t a;
        for (int i = 0; i < pairs; i++)
        begin
            a = data_t'($urandom);
            queue_response(a);
            if (i == pairs - 1)
                queue_response(a);
            else
                queue_response(a ^ data_t'($urandom_range(1, 16'hFFFF)));
        end
    endtask

    task automatic queue_program(input addr_t addr, input data_t data, input logic fin,
                                 input bit erased, input int pairs);
        push_request(CMD_PROGRAM, addr, 4'($urandom), data, fin, 1'b1);
        if (erased)
        begin
            queue_response(ERASED);
            queue_polls(pairs);
        end
        else
            queue_response(not_erased_word());
    endtask

    task automatic queue_erase(input logic [3:0] sector, input int pairs);
        push_request(CMD_ERASE, addr_t'($urandom), sector, data_t'($urandom), 1'($urandom),
                     1'b1);
        queue_polls(pairs);
    endtask

    // clean_words erased reads, then a dirty word unless the scan runs to the end
    task automatic queue_blank(input logic [3:0] sector, input int clean_words,
                               input bit ends_blank);
        push_request(CMD_BLANK, addr_t'($urandom), sector, data_t'($urandom), 1'($urandom),
                     1'b1);
        repeat (clean_words)
            queue_response(ERASED);
        if (!ends_blank)
            queue_response(not_erased_word());
    endtask

    // ------------------------------------------------------------------
    // Driver: presents requests at the falling edge. A request is held
    // until it has been taken; the idling mix follows the request's pace.
    // Pace 0 no idling, 1 sender idle, 2 receiver stalls, 3 both lightly.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        flash_req_t nxt;
        int         send_idle;
        int         recv_stall;
        send_idle  = (drive_pace == 2'd1) ? 66 : (drive_pace == 2'd3) ? 17 : 0;
        recv_stall = (drive_pace == 2'd2) ? 66 : (drive_pace == 2'd3) ? 17 : 0;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (!req_ch.valid || req_fired)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = pending_requests.pop_front();
                    drive_pace = nxt.pace;
                    req_ch.valid         <= 1'b1;
                    req_ch.command       <= nxt.command;
                    req_ch.word_address  <= nxt.word_address;
                    req_ch.sector_number <= nxt.sector_number;
                    req_ch.data_word     <= nxt.data_word;
                    req_ch.final_word    <= nxt.final_word;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, a taken request feeds the predictor and
    // a taken result is checked against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic string describe(input flash_result_t r);
        return $sformatf("wr=%0b addr=%06h data=%04h status=%0d last=%0b",
                         r.bus_write, r.bus_address, r.bus_data, r.status, r.last);
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : watch_channels
        flash_result_t got;
        flash_result_t want;
        req_fired <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                predict_request(req_ch.command, req_ch.word_address, req_ch.sector_number,
                                req_ch.data_word, req_ch.final_word);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{bus_write: rsp_ch.bus_write, bus_address: rsp_ch.bus_address,
                        bus_data: rsp_ch.bus_data, status: rsp_ch.status,
                        last: rsp_ch.last};
                if (expected_results.size() == 0)
                    log_failure({"unexpected result: ", describe(got)});
                else
                begin
                    want = expected_results.pop_front();
                    if (got.bus_write !== want.bus_write
                        || got.bus_address !== want.bus_address
                        || got.bus_data !== want.bus_data
                        || got.status !== want.status
                        || got.last !== want.last)
                        log_failure({"mismatch: expected ", describe(want),
                                     " got ", describe(got)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build all stimulus, reset, then drain.
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int pick;
        rst_n = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_PROGRAM;
        req_ch.word_address  = '0;
        req_ch.sector_number = '0;
        req_ch.data_word     = '0;
        req_ch.final_word    = 1'b0;
        rsp_ch.ready         = 1'b0;

        // directed corner cases, no idling
        gen_pace = 2'd0;
        busy_noise_on = 1'b0;
        push_request(CMD_RESPONSE, '0, '0, 16'h1234, 1'b0, 1'b0);   // response while idle
        push_request(CMD_ERASE, '0, 4'd13, '0, 1'b0, 1'b0);         // first bad sector
        push_request(CMD_BLANK, '1, 4'd15, '1, 1'b1, 1'b0);         // top sector code
        queue_program('0, 16'h0000, 1'b1, 1'b1, 1);                 // lowest address, final
        // top address, all-ones data, not final, with a request while busy
        push_request(CMD_PROGRAM, '1, 4'd12, ERASED, 1'b0, 1'b1);
        queue_response(ERASED);
        push_request(CMD_ERASE, '0, 4'd3, '0, 1'b0, 1'b0);
        queue_polls(1);
        queue_program(addr_t'(21'h0AAAAA), 16'h5555, 1'b1, 1'b0, 0); // word not erased
        queue_erase(4'd12, 2);                                       // last sector, one toggle
        queue_blank(4'd0, 1, 1'b0);                                  // dirty second word
        queue_erase(4'd0, 1);

        // random part, pace stepping through the idling mixes
        busy_noise_on = 1'b1;
        while (counted_reqs < TARGET_REQS)
        begin
            gen_pace = 2'((counted_reqs * 4) / TARGET_REQS);
            pick = $urandom_range(99);
            if (pick < 35)
                queue_program(addr_t'($urandom), data_t'($urandom), 1'($urandom),
                              $urandom_range(4) != 0, $urandom_range(1, 3));
            else if (pick < 55)
                queue_erase(4'($urandom_range(SECTORS - 1)), $urandom_range(1, 3));
            else if (pick < 75)
                queue_blank(4'($urandom_range(SECTORS - 1)),
                            ($urandom_range(7) == 0) ? $urandom_range(20)
                                                     : $urandom_range(6), 1'b0);
            else if (pick < 85)
                push_request(CMD_RESPONSE, addr_t'($urandom), 4'($urandom),
                             data_t'($urandom), 1'($urandom), 1'b0);
            else
                push_request($urandom_range(1) ? CMD_ERASE : CMD_BLANK, addr_t'($urandom),
                             4'($urandom_range(SECTORS, 15)), data_t'($urandom),
                             1'($urandom), 1'b0);
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // everything taken, then every expectation met, then a short quiet spell
        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### nor_flash_command_sequencer_unit.f
rtl/core/nfcs_pkg.sv
rtl/core/nfcs_req_if.sv
rtl/core/nfcs_rsp_if.sv
rtl/core/nfcs_front.sv
rtl/core/nfcs_queue.sv
rtl/core/nfcs_back.sv
rtl/core/nor_flash_command_sequencer_unit.sv
bench/tb.sv
